// ----- hw/rtl/grod_pkg.sv -----
package grod_pkg;

    localparam int unsigned ROW_W     = 8;
    localparam int unsigned MASK_W    = 12;
    localparam int unsigned ROW_IDX_W = 6;
    localparam int unsigned HGT_W     = 6;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned HIST_D    = 4;
    localparam int unsigned WIN_D     = HIST_D + 1;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned CLAMP_W   = 8;

    localparam int unsigned MAX_GLYPH_HEIGHT = 32;

    localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OUT3   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUT5   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [HGT_W-1:0] HEIGHT_RESET = 6'd8;

    localparam logic [CNT_W-1:0] HALO_NONE = 3'd0;
    localparam logic [CNT_W-1:0] HALO_OUT3 = 3'd2;
    localparam logic [CNT_W-1:0] HALO_OUT5 = 3'd4;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [MASK_W-1:0] LEFT_BIT10 = 12'h200;
    localparam logic [MASK_W-1:0] LEFT_BIT12 = 12'h800;

    typedef logic [WIN_D-1:0][ROW_W-1:0] t_win;

    typedef struct packed {
        t_win                   win;
        logic [MODE_W-1:0]      mode;
        logic [ROW_IDX_W-1:0]   row;
        logic [CNT_W-1:0]       count;
        logic                   col_end;
    } t_job;

    function automatic logic [MASK_W-1:0] dilate(input logic [MODE_W-1:0] mode,
                                                 input t_win win);
        logic [ROW_W-1:0]  s8;
        logic [ROW_W-1:0]  e8;
        logic [MASK_W-1:0] s;
        logic [MASK_W-1:0] e;
        logic [MASK_W-1:0] res;
        s8  = '0;
        e8  = '0;
        s   = '0;
        e   = '0;
        res = '0;
        unique case (mode)
            MODE_OUT3: begin
                s8  = win[0] | win[1] | win[2];
                s   = {4'b0, s8};
                s   = (s | (s << 1) | (s << 2)) & ((LEFT_BIT10 << 1) - 12'd1);
                res = s << 2;
            end
            MODE_OUT5: begin
                s8  = win[1] | win[2] | win[3];
                e8  = s8 | win[0] | win[4];
                s   = {4'b0, s8};
                e   = {4'b0, e8};
                res = s | (s << 1) | (s << 2) | (s << 3) | (s << 4)
                    | (e << 1) | (e << 2) | (e << 3);
                res = res & ((LEFT_BIT12 << 1) - 12'd1);
            end
            default: begin
                res = {win[0], 4'b0};
            end
        endcase
        return res;
    endfunction

endpackage

// ----- hw/rtl/grod_hist.sv -----
module grod_hist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [grod_pkg::ROW_W-1:0]          i_row_bits,
    input  logic [grod_pkg::MODE_W-1:0]         i_mode,
    input  logic [grod_pkg::HGT_W-1:0]          i_height,
    output grod_pkg::t_job                      o_job
);

    logic [grod_pkg::HIST_D-1:0][grod_pkg::ROW_W-1:0] r_hist;
    logic [grod_pkg::HIST_D-1:0][grod_pkg::ROW_W-1:0] n_hist;
    logic [grod_pkg::ROW_IDX_W-1:0]                   r_row_count;
    logic [grod_pkg::ROW_IDX_W-1:0]                   n_row_count;

    logic [grod_pkg::MODE_W-1:0]  mode_eff;
    logic [grod_pkg::CNT_W-1:0]   halo;
    logic [grod_pkg::CLAMP_W-1:0] h_eff;
    logic [grod_pkg::CLAMP_W-1:0] row_next;
    logic                         last;

    always_comb begin
        mode_eff = (i_mode == grod_pkg::MODE_UNUSED) ? grod_pkg::MODE_PLAIN : i_mode;
        unique case (mode_eff)
            grod_pkg::MODE_OUT3: halo = grod_pkg::HALO_OUT3;
            grod_pkg::MODE_OUT5: halo = grod_pkg::HALO_OUT5;
            default:             halo = grod_pkg::HALO_NONE;
        endcase

        h_eff = {2'b0, i_height};
        if (h_eff == '0) begin
            h_eff = grod_pkg::CLAMP_W'(1);
        end
        if (h_eff > grod_pkg::CLAMP_W'(grod_pkg::MAX_GLYPH_HEIGHT)) begin
            h_eff = grod_pkg::CLAMP_W'(grod_pkg::MAX_GLYPH_HEIGHT);
        end
        row_next = {2'b0, r_row_count} + grod_pkg::CLAMP_W'(1);
        last     = (row_next >= h_eff);

        o_job.win     = {r_hist, i_row_bits};
        o_job.mode    = mode_eff;
        o_job.row     = r_row_count;
        o_job.count   = last ? (halo + grod_pkg::CNT_W'(1)) : grod_pkg::CNT_W'(1);
        o_job.col_end = last;

        if (last) begin
            n_hist      = '0;
            n_row_count = '0;
        end else begin
            n_hist      = {r_hist[grod_pkg::HIST_D-2:0], i_row_bits};
            n_row_count = row_next[grod_pkg::ROW_IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_row_count <= '0;
        end else if (i_load) begin
            r_hist      <= n_hist;
            r_row_count <= n_row_count;
        end
    end

endmodule

// ----- hw/rtl/grod_emit.sv -----
module grod_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  grod_pkg::t_job                      i_job,
    output logic                                o_ready,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [grod_pkg::MASK_W-1:0]         o_pixel_mask,
    output logic [grod_pkg::ROW_IDX_W-1:0]      o_out_row,
    output logic                                o_column_done
);

    logic                              r_busy;
    grod_pkg::t_job                    r_job;
    logic                              r_out_valid;
    logic [grod_pkg::MASK_W-1:0]       r_mask;
    logic [grod_pkg::ROW_IDX_W-1:0]    r_row;
    logic                              r_done;

    logic                              advance;
    logic                              final_res;
    grod_pkg::t_job                    n_job;

    always_comb begin
        advance   = r_busy && (!r_out_valid || !i_stall);
        final_res = (r_job.count == grod_pkg::CNT_W'(1));
        o_ready   = !r_busy || (advance && final_res);

        n_job       = r_job;
        n_job.win   = {r_job.win[grod_pkg::WIN_D-2:0], grod_pkg::ROW_W'(0)};
        n_job.row   = r_job.row + grod_pkg::ROW_IDX_W'(1);
        n_job.count = r_job.count - grod_pkg::CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
            end else if (advance && final_res) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end else if (advance) begin
            r_job <= n_job;
        end
        if (advance) begin
            r_mask <= grod_pkg::dilate(r_job.mode, r_job.win);
            r_row  <= r_job.row;
            r_done <= final_res && r_job.col_end;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_mask  = r_mask;
    assign o_out_row     = r_row;
    assign o_column_done = r_done;

endmodule

// ----- hw/rtl/glyph_row_outline_dilation_unit.sv -----
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------------------------
// in       | i_in_valid   | o_in_stall   | i_row_bits
// out      | o_out_valid  | i_out_stall  | o_pixel_mask, o_out_row, o_column_done
//
// One glyph row per cycle, one emitter result per cycle, each unless stalled.
// Last row of a column gives 3 results in 3x3 mode and 5 in 5x5 mode, so that
// transaction holds the input while the emitter drains the 2 or 4 halo rows.
// Input rows register into the emitter job, then results into the output registers.
// Synchronous active-low reset clears history, row count, valids; presets config.
// A stalled result holds; the emitter keeps one job behind it.
module glyph_row_outline_dilation_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [grod_pkg::ROW_W-1:0]          i_row_bits,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [grod_pkg::MASK_W-1:0]         o_pixel_mask,
    output logic [grod_pkg::ROW_IDX_W-1:0]      o_out_row,
    output logic                                o_column_done
);

    logic [grod_pkg::MODE_W-1:0] r_mode;
    logic [grod_pkg::HGT_W-1:0]  r_height;

    logic           wr_en;
    logic           reg_sel;
    logic           ready;
    logic           load;
    grod_pkg::t_job job;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= grod_pkg::MODE_PLAIN;
            r_height <= grod_pkg::HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                grod_pkg::REG_MODE:   r_mode   <= pwdata[grod_pkg::MODE_W-1:0];
                grod_pkg::REG_HEIGHT: r_height <= pwdata[grod_pkg::HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            grod_pkg::REG_MODE:   prdata = {30'b0, r_mode};
            grod_pkg::REG_HEIGHT: prdata = {26'b0, r_height};
            default:              prdata = '0;
        endcase
    end

    assign o_in_stall = !ready;
    assign load       = i_in_valid && ready;

    grod_hist u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_row_bits (i_row_bits),
        .i_mode     (r_mode),
        .i_height   (r_height),
        .o_job      (job)
    );

    grod_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_job         (job),
        .o_ready       (ready),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_pixel_mask  (o_pixel_mask),
        .o_out_row     (o_out_row),
        .o_column_done (o_column_done)
    );

endmodule

// ----- hw/rtl/grod_chk.sv -----
module grod_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [11:0] o_pixel_mask,
    input logic [5:0]  o_out_row,
    input logic        o_column_done
);

    // row index runs on within a column
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_column_done) ##1 o_out_valid
        |-> o_out_row == $past(o_out_row) + 6'd1)
        else $error("out_row did not advance within column");

    // a new column starts at row zero
    a_col_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_column_done) ##1 o_out_valid
        |-> o_out_row == 6'd0)
        else $error("column did not restart at row zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall
        |=> o_out_valid && $stable(o_pixel_mask) && $stable(o_out_row)
            && $stable(o_column_done))
        else $error("stalled transaction changed");

endmodule

bind glyph_row_outline_dilation_unit grod_chk u_grod_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_pixel_mask  (o_pixel_mask),
    .o_out_row     (o_out_row),
    .o_column_done (o_column_done)
);
